// ===== rtl/pip_pkg.sv =====
// Shared constants and transaction types of the point-in-polygon test.
package pip_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int COORD_WIDTH  = 32;
   localparam int FIELD_WIDTH  = 32;
   localparam int TOTAL_WIDTH  = 7;
   localparam int ADDR_WIDTH   = $clog2(MAX_VERTICES);
   localparam int COUNT_WIDTH  = $clog2(MAX_VERTICES + 1);

   localparam logic OP_VERTEX = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   typedef struct packed {
      logic                          op;
      logic                          start_new;
      logic signed [FIELD_WIDTH-1:0] coord_x;
      logic signed [FIELD_WIDTH-1:0] coord_y;
   } req_type;

   typedef struct packed {
      logic                   inside_res;
      logic [TOTAL_WIDTH-1:0] vertex_total;
   } rsp_type;

   typedef struct packed {
      logic                  idle;
      logic                  write_vertex;
      logic                  start_query;
      logic                  rd_en;
      logic                  rd_edge;
      logic [ADDR_WIDTH-1:0] rd_addr;
      logic                  load_result;
   } cmd_type;

   typedef struct packed {
      logic                   busy;
      logic                   out_free;
      logic [COUNT_WIDTH-1:0] count;
   } status_type;

endpackage

// ===== rtl/pip_ctrl.sv =====
// Sequencer that takes vertex writes and walks the stored polygon edges for each query.
module pip_ctrl import pip_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_op,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_LOAD  = 5'b00010,
      ST_WALK  = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [ADDR_WIDTH-1:0] idx_ff, idx_in;
   logic [ADDR_WIDTH-1:0] last_addr;

   assign last_addr = ADDR_WIDTH'(status.count - COUNT_WIDTH'(1));

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.idle = 1'b1;
            if (req_valid) begin
               if (req_op == OP_VERTEX) begin
                  cmd.write_vertex = 1'b1;
               end else begin
                  cmd.start_query = 1'b1;
                  state_in = (status.count == '0) ? ST_DONE : ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            // The last vertex is read first so that it pairs with vertex zero.
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = last_addr;
            idx_in      = '0;
            state_in    = ST_WALK;
         end
         ST_WALK: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_edge = 1'b1;
            cmd.rd_addr = idx_ff;
            idx_in      = idx_ff + ADDR_WIDTH'(1);
            if (idx_ff == last_addr) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.load_result = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

// ===== rtl/pip_datapath.sv =====
// Vertex store, edge crossing pipeline and result register.
module pip_datapath import pip_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   input  req_type    req_payload,
   output status_type status,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output rsp_type    rsp_payload
);

   localparam int CW = COORD_WIDTH;
   localparam int DW = CW + 1;
   localparam int PW = 2 * DW + 1;

   logic [2*CW-1:0] vertex_mem [MAX_VERTICES];

   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [COUNT_WIDTH-1:0] base;
   logic                   wr_en;
   logic signed [CW-1:0]   cx, cy;
   logic signed [CW-1:0]   qx_ff, qy_ff;
   logic [2*CW-1:0]        rd_data_ff, prev_ff;
   logic                   rd_edge_ff;

   logic signed [CW-1:0]   xi, yi, xj, yj;
   logic signed [DW-1:0]   dy, lx_in, rx_in, ry;
   logic [DW-1:0]          ady_in, ary_in;
   logic                   cross_in;

   logic                   s1_valid_ff, s1_cross_ff;
   logic signed [DW-1:0]   lx_ff, rx_ff;
   logic [DW-1:0]          ady_ff, ary_ff;

   logic                   s2_valid_ff, s2_cross_ff;
   logic signed [PW-1:0]   pl_ff, pl_in, pr_ff, pr_in;

   logic                   inside_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff;

   assign cx = req_payload.coord_x[CW-1:0];
   assign cy = req_payload.coord_y[CW-1:0];

   // A full store drops further vertices; a new polygon restarts at zero.
   always_comb begin
      base     = req_payload.start_new ? '0 : count_ff;
      count_in = count_ff;
      wr_en    = 1'b0;
      if (cmd.write_vertex) begin
         count_in = base;
         if (base < COUNT_WIDTH'(MAX_VERTICES)) begin
            wr_en    = 1'b1;
            count_in = base + COUNT_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         vertex_mem[base[ADDR_WIDTH-1:0]] <= {cx, cy};
      end
      if (cmd.rd_en) begin
         rd_data_ff <= vertex_mem[cmd.rd_addr];
         prev_ff    <= rd_data_ff;
      end
      if (cmd.start_query) begin
         qx_ff <= cx;
         qy_ff <= cy;
      end
   end

   // Edge from vertex i (just read) to vertex j (read the cycle before).
   always_comb begin
      xi = rd_data_ff[2*CW-1:CW];
      yi = rd_data_ff[CW-1:0];
      xj = prev_ff[2*CW-1:CW];
      yj = prev_ff[CW-1:0];
      dy    = DW'(yj) - DW'(yi);
      lx_in = DW'(qx_ff) - DW'(xi);
      rx_in = DW'(xj) - DW'(xi);
      ry    = DW'(qy_ff) - DW'(yi);
      ady_in   = dy[DW-1] ? (~dy + DW'(1)) : dy;
      ary_in   = ry[DW-1] ? (~ry + DW'(1)) : ry;
      cross_in = (yi > qy_ff) != (yj > qy_ff);
   end

   // The crossing test qx < xi + rx*ry/dy becomes lx*|dy| < rx*|ry|.
   assign pl_in = PW'(lx_ff) * PW'($signed({1'b0, ady_ff}));
   assign pr_in = PW'(rx_ff) * PW'($signed({1'b0, ary_ff}));

   always_ff @(posedge clock) begin
      lx_ff       <= lx_in;
      rx_ff       <= rx_in;
      ady_ff      <= ady_in;
      ary_ff      <= ary_in;
      s1_cross_ff <= cross_in;
      pl_ff       <= pl_in;
      pr_ff       <= pr_in;
      s2_cross_ff <= s1_cross_ff;
      if (cmd.load_result) begin
         rsp_ff.inside_res   <= inside_ff;
         rsp_ff.vertex_total <= TOTAL_WIDTH'(count_ff);
      end
   end

   assign rsp_valid_in = cmd.load_result | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_edge_ff   <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         inside_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rd_edge_ff   <= cmd.rd_en & cmd.rd_edge;
         s1_valid_ff  <= rd_edge_ff;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.start_query) begin
            inside_ff <= 1'b0;
         end else if (s2_valid_ff && s2_cross_ff && (pl_ff < pr_ff)) begin
            inside_ff <= ~inside_ff;
         end
      end
   end

   assign status.busy     = rd_edge_ff | s1_valid_ff | s2_valid_ff;
   assign status.out_free = ~rsp_valid_ff | ~rsp_stall;
   assign status.count    = count_ff;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== rtl/point_in_polygon_test.sv =====
// Crossing-number point-in-polygon test: stores up to MAX_VERTICES corners in
// signed Q16.16 and answers one query transaction at a time. Vertex transactions
// are taken back to back. A query walks the stored edges through the vertex
// memory's single read port, one vertex per cycle, and then drains a three-stage
// crossing pipeline (differences, two exact products, compare), so it holds the
// input until the walk and the drain are done (an empty polygon skips both),
// and further while an earlier result still waits in a stalled output register.
// The result sits in an output register, so the next transaction is taken while
// a finished result still waits to be read.
module point_in_polygon_test import pip_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   cmd_type    cmd;
   status_type status;

   pip_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_payload.op),
      .status    (status),
      .cmd       (cmd)
   );

   pip_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .status      (status),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   assign req_stall = ~cmd.idle;

endmodule

// ===== rtl/pip_checker.sv =====
// Port-level assertions for the point-in-polygon test and their binding.
module pip_checker import pip_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_payload,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   // A stalled result must hold.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled result transaction changed");

   // A query keeps the input closed while its edges are walked.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_payload.op == OP_QUERY) |=> req_stall)
      else $error("input open right after a query transaction");

   // Vertex transactions never close the input.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_payload.op == OP_VERTEX) |=> !req_stall)
      else $error("input closed after a vertex transaction");

   // A new result only appears at the end of a query.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result transaction without a query in progress");

   // Fewer than three corners enclose nothing.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.inside_res) |-> (rsp_payload.vertex_total >= TOTAL_WIDTH'(3)))
      else $error("inside reported for a degenerate polygon");

endmodule

bind point_in_polygon_test pip_checker u_checker (.*);
